### hdl/rtc_drift_reconciler_macros.svh
// Assertion macros shared by the checker files.
`ifndef RTC_DRIFT_RECONCILER_MACROS_SVH
`define RTC_DRIFT_RECONCILER_MACROS_SVH

// Same-cycle implication, sampled on the block clock.
`define RDR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtc drift reconciler check failed");

// Next-cycle implication, sampled on the block clock.
`define RDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtc drift reconciler check failed");

`endif

### hdl/rdr_pkg.sv
// Shared types, codes and constants of the RTC drift reconciler.
package rdr_pkg;

    // opcodes
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_NTP   = 2'd1;
    localparam logic [1:0] OP_TIMER = 2'd2;

    // result actions
    localparam logic [2:0] ACT_SKIP      = 3'd0;
    localparam logic [2:0] ACT_IN_TOL    = 3'd1;
    localparam logic [2:0] ACT_SYS_RTC   = 3'd2;
    localparam logic [2:0] ACT_SYS_STALE = 3'd3;
    localparam logic [2:0] ACT_WRITE_RTC = 3'd4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_RTC_AVAIL = 2'd0;
    localparam logic [1:0] REG_RTC_VALID = 2'd1;
    localparam logic [1:0] REG_CHECK_IVL = 2'd2;
    localparam logic [1:0] REG_TRUST_WIN = 2'd3;

    localparam logic [31:0] CHECK_IVL_RST = 32'd3600000;
    localparam logic [31:0] TRUST_WIN_RST = 32'd300000;

    localparam logic [3:0]         MONTH_FEB  = 4'd2;
    localparam logic [10:0]        RECIP_100  = 11'd1311;   // 2^17 / 100, rounded up
    localparam logic signed [21:0] DAYS_365   = 22'sd365;
    localparam logic signed [21:0] DAYS_OFS   = 22'sd719469;
    localparam logic signed [39:0] SECS_DAY   = 40'sd86400;
    localparam logic [16:0]        SECS_HOUR  = 17'd3600;
    localparam logic [16:0]        SECS_MIN   = 17'd60;
    localparam logic signed [40:0] DRIFT_MAX  = 41'sd4294967295;
    localparam logic signed [40:0] DRIFT_MIN  = -41'sd4294967295;
    localparam logic signed [40:0] DRIFT_ONE  = 41'sd1;
    localparam logic signed [40:0] DRIFT_MONE = -41'sd1;
    localparam logic signed [39:0] EPOCH_MAX  = 40'sd4294967295;

    typedef struct packed {
        logic        rtc_available;
        logic        rtc_time_valid;
        logic [31:0] check_interval_ms;
        logic [31:0] trust_window_ms;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic calc_days;
        logic calc_secs;
        logic commit;
    } t_cmd;

    // days before the month, March-based year; Jan/Feb (and 0) wrap to months 13/14/12
    function automatic logic [8:0] month_days(input logic [3:0] month);
        logic [8:0] res;
        case (month)
            4'd0:    res = 9'd275;
            4'd1:    res = 9'd306;
            4'd2:    res = 9'd337;
            4'd3:    res = 9'd0;
            4'd4:    res = 9'd31;
            4'd5:    res = 9'd61;
            4'd6:    res = 9'd92;
            4'd7:    res = 9'd122;
            4'd8:    res = 9'd153;
            4'd9:    res = 9'd184;
            4'd10:   res = 9'd214;
            4'd11:   res = 9'd245;
            4'd12:   res = 9'd275;
            4'd13:   res = 9'd306;
            4'd14:   res = 9'd337;
            default: res = 9'd367;
        endcase
        return res;
    endfunction

endpackage

### hdl/rdr_regs.sv
// APB configuration registers of the RTC drift reconciler.
module rdr_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rdr_pkg::t_cfg o_cfg
);

    rdr_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rtc_available     <= 1'b0;
            r_cfg.rtc_time_valid    <= 1'b0;
            r_cfg.check_interval_ms <= rdr_pkg::CHECK_IVL_RST;
            r_cfg.trust_window_ms   <= rdr_pkg::TRUST_WIN_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                rdr_pkg::REG_RTC_AVAIL: r_cfg.rtc_available     <= pwdata[0];
                rdr_pkg::REG_RTC_VALID: r_cfg.rtc_time_valid    <= pwdata[0];
                rdr_pkg::REG_CHECK_IVL: r_cfg.check_interval_ms <= pwdata;
                rdr_pkg::REG_TRUST_WIN: r_cfg.trust_window_ms   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rdr_pkg::REG_RTC_AVAIL: prdata = {31'd0, r_cfg.rtc_available};
            rdr_pkg::REG_RTC_VALID: prdata = {31'd0, r_cfg.rtc_time_valid};
            rdr_pkg::REG_CHECK_IVL: prdata = r_cfg.check_interval_ms;
            rdr_pkg::REG_TRUST_WIN: prdata = r_cfg.trust_window_ms;
            default:                prdata = 32'd0;
        endcase
    end

endmodule

### hdl/rdr_ctrl.sv
// Sequencing state machine of the RTC drift reconciler.
module rdr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rdr_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DAYS = 2'd1;
    localparam logic [1:0] ST_SECS = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    // result slot is free now or is emptied at this edge
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.calc_days = 1'b0;
        o_cmd.calc_secs = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DAYS;
                end
            end
            ST_DAYS: begin
                o_cmd.calc_days = 1'b1;
                n_state         = ST_SECS;
            end
            ST_SECS: begin
                o_cmd.calc_secs = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/rdr_dp.sv
// Datapath: date-to-epoch arithmetic, drift decision, timer state and result beat.
module rdr_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rdr_pkg::t_cmd       i_cmd,
    input  rdr_pkg::t_cfg       i_cfg,
    input  logic [1:0]          i_opcode,
    input  logic [31:0]         i_now_ms,
    input  logic [11:0]         i_rtc_year,
    input  logic [3:0]          i_rtc_month,
    input  logic [4:0]          i_rtc_day,
    input  logic [4:0]          i_rtc_hour,
    input  logic [5:0]          i_rtc_minute,
    input  logic [5:0]          i_rtc_second,
    input  logic [31:0]         i_system_epoch,
    output logic [2:0]          o_action,
    output logic [31:0]         o_target_epoch,
    output logic signed [32:0]  o_drift_seconds
);

    // captured beat
    logic [1:0]  r_op;
    logic [31:0] r_now;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic [31:0] r_sys;

    // arithmetic stages
    logic signed [21:0] r_days;
    logic [16:0]        r_tod;
    logic signed [39:0] r_epoch;

    // timer state
    logic [31:0] r_last_check, r_last_ntp;

    // result
    logic [2:0]         r_action, n_action;
    logic [31:0]        r_target, n_target;
    logic signed [32:0] r_drift, n_drift;

    // day count
    logic               feb_or_jan;
    logic signed [12:0] y_adj;
    logic [11:0]        y_u;
    logic [22:0]        q_prod;
    logic [5:0]         q100;
    logic [3:0]         q400;
    logic [9:0]         q4;
    logic signed [21:0] n_days;
    logic [16:0]        n_tod;
    logic signed [39:0] n_epoch;

    // decision
    logic signed [40:0] drift;
    logic [31:0]        since_check, since_ntp;
    logic               run_check, fresh, in_tol, drift_neg;
    logic [32:0]        drift_sat;
    logic [31:0]        epoch_sat;

    always_comb begin
        feb_or_jan = (r_month <= rdr_pkg::MONTH_FEB);
        y_adj      = $signed({1'b0, r_year}) - $signed({12'd0, feb_or_jan});
        y_u        = y_adj[12] ? 12'd0 : y_adj[11:0];
        q_prod     = 23'(y_u) * 23'(rdr_pkg::RECIP_100);
        q100       = q_prod[22:17];
        q400       = q100[5:2];
        q4         = y_u[11:2];
        n_days     = 22'(y_adj) * rdr_pkg::DAYS_365
                   + $signed(22'(q4)) - $signed(22'(q100)) + $signed(22'(q400))
                   + $signed(22'(rdr_pkg::month_days(r_month)))
                   + $signed(22'(r_day)) - rdr_pkg::DAYS_OFS;
        n_tod      = 17'(r_hour) * rdr_pkg::SECS_HOUR + 17'(r_minute) * rdr_pkg::SECS_MIN
                   + 17'(r_second);
        n_epoch    = 40'(r_days) * rdr_pkg::SECS_DAY + $signed(40'(r_tod));
    end

    always_comb begin
        drift       = $signed({9'd0, r_sys}) - 41'(r_epoch);
        since_check = r_now - r_last_check;
        since_ntp   = r_now - r_last_ntp;
        run_check   = (r_op == rdr_pkg::OP_CHECK) && i_cfg.rtc_available
                   && i_cfg.rtc_time_valid && (since_check >= i_cfg.check_interval_ms);
        fresh       = (r_last_ntp != 32'd0) && (since_ntp < i_cfg.trust_window_ms);
        in_tol      = (drift >= rdr_pkg::DRIFT_MONE) && (drift <= rdr_pkg::DRIFT_ONE);
        drift_neg   = (drift < rdr_pkg::DRIFT_MONE);

        if (drift > rdr_pkg::DRIFT_MAX) begin
            drift_sat = rdr_pkg::DRIFT_MAX[32:0];
        end else if (drift < rdr_pkg::DRIFT_MIN) begin
            drift_sat = rdr_pkg::DRIFT_MIN[32:0];
        end else begin
            drift_sat = drift[32:0];
        end

        if (r_epoch < 40'sd0) begin
            epoch_sat = 32'd0;
        end else if (r_epoch > rdr_pkg::EPOCH_MAX) begin
            epoch_sat = 32'hFFFF_FFFF;
        end else begin
            epoch_sat = r_epoch[31:0];
        end

        n_action = rdr_pkg::ACT_SKIP;
        n_target = 32'd0;
        n_drift  = 33'sd0;
        if (run_check) begin
            n_drift = $signed(drift_sat);
            if (in_tol) begin
                n_action = rdr_pkg::ACT_IN_TOL;
            end else if (drift_neg) begin
                n_action = rdr_pkg::ACT_SYS_RTC;
                n_target = epoch_sat;
            end else if (!fresh) begin
                n_action = rdr_pkg::ACT_SYS_STALE;
                n_target = epoch_sat;
            end else begin
                n_action = rdr_pkg::ACT_WRITE_RTC;
                n_target = r_sys;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_now    <= i_now_ms;
            r_year   <= i_rtc_year;
            r_month  <= i_rtc_month;
            r_day    <= i_rtc_day;
            r_hour   <= i_rtc_hour;
            r_minute <= i_rtc_minute;
            r_second <= i_rtc_second;
            r_sys    <= i_system_epoch;
        end
        if (i_cmd.calc_days) begin
            r_days <= n_days;
            r_tod  <= n_tod;
        end
        if (i_cmd.calc_secs) begin
            r_epoch <= n_epoch;
        end
        if (i_cmd.commit) begin
            r_action <= n_action;
            r_target <= n_target;
            r_drift  <= n_drift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_check <= 32'd0;
            r_last_ntp   <= 32'd0;
        end else if (i_cmd.commit) begin
            if (r_op == rdr_pkg::OP_NTP) begin
                r_last_ntp <= r_now;
            end
            if ((r_op == rdr_pkg::OP_TIMER) || run_check) begin
                r_last_check <= r_now;
            end
        end
    end

    assign o_action        = r_action;
    assign o_target_epoch  = r_target;
    assign o_drift_seconds = r_drift;

endmodule

### hdl/rtc_drift_reconciler.sv
// Top level of the RTC drift reconciler.
//
//   channel   handshake                  payload
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//   in        i_in_valid / o_in_stall    opcode, now_ms, rtc date and time, system_epoch
//   out       o_out_valid / i_out_stall  action, target_epoch, drift_seconds
//
// One item at a time, in four steps (capture, day count, seconds multiply,
// drift decision and commit), set by the controller's sequence through the datapath.
// A stalled result holds the finish step; the next item is taken while a result waits.
// Reset is synchronous, active low; it resets config and clears check and sync timers.
module rtc_drift_reconciler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_opcode,
    input  logic [31:0]         i_now_ms,
    input  logic [11:0]         i_rtc_year,
    input  logic [3:0]          i_rtc_month,
    input  logic [4:0]          i_rtc_day,
    input  logic [4:0]          i_rtc_hour,
    input  logic [5:0]          i_rtc_minute,
    input  logic [5:0]          i_rtc_second,
    input  logic [31:0]         i_system_epoch,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_action,
    output logic [31:0]         o_target_epoch,
    output logic signed [32:0]  o_drift_seconds
);

    rdr_pkg::t_cfg cfg;
    rdr_pkg::t_cmd cmd;

    rdr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    rdr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .i_opcode        (i_opcode),
        .i_now_ms        (i_now_ms),
        .i_rtc_year      (i_rtc_year),
        .i_rtc_month     (i_rtc_month),
        .i_rtc_day       (i_rtc_day),
        .i_rtc_hour      (i_rtc_hour),
        .i_rtc_minute    (i_rtc_minute),
        .i_rtc_second    (i_rtc_second),
        .i_system_epoch  (i_system_epoch),
        .o_action        (o_action),
        .o_target_epoch  (o_target_epoch),
        .o_drift_seconds (o_drift_seconds)
    );

endmodule

### hdl/rdr_checker.sv
// Port-level assertion checker of the RTC drift reconciler, bound to the top level.
`include "rtc_drift_reconciler_macros.svh"

module rdr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_action,
    input logic [31:0]        o_target_epoch,
    input logic signed [32:0] o_drift_seconds
);

    `RDR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_action) && $stable(o_target_epoch) && $stable(o_drift_seconds))

    `RDR_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall)

    `RDR_ASSERT_NOW(a_result_latency, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 4))

    `RDR_ASSERT_NOW(a_skip_zero, o_out_valid && (o_action == rdr_pkg::ACT_SKIP || o_action == rdr_pkg::ACT_IN_TOL), o_target_epoch == 32'd0 && (o_action == rdr_pkg::ACT_IN_TOL || o_drift_seconds == 33'sd0))

    `RDR_ASSERT_NOW(a_write_rtc_pos, o_out_valid && o_action == rdr_pkg::ACT_WRITE_RTC, !o_drift_seconds[32] && o_drift_seconds > 33'sd1)

endmodule

bind rtc_drift_reconciler rdr_checker u_rdr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_action        (o_action),
    .o_target_epoch  (o_target_epoch),
    .o_drift_seconds (o_drift_seconds)
);

### tb/rtc_drift_reconciler_tb.sv
// Self-checking testbench for the RTC drift reconciler: directed table, random phases.
module rtc_drift_reconciler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE = 8;
    localparam int N_PHASES = 12;
    localparam int PHASE_ITEMS = 155;
    localparam longint DRIFT_LIM = 64'sd4294967295;
    localparam longint EPOCH_TOP = 64'sd4294967295;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] sys_epoch;
    } t_rtc_item;

    typedef struct packed {
        logic [2:0]         action;
        logic [31:0]        target;
        logic signed [32:0] drift;
    } t_recon;

    typedef struct {
        t_rtc_item it;
        bit        fixed;
        t_recon    res;
    } t_beat;

    typedef struct {
        int    step;
        t_beat b;
    } t_row;

    localparam t_recon NO_RESULT = '{rdr_pkg::ACT_SKIP, 32'd0, 33'sd0};

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic [31:0]        i_now_ms;
    logic [11:0]        i_rtc_year;
    logic [3:0]         i_rtc_month;
    logic [4:0]         i_rtc_day;
    logic [4:0]         i_rtc_hour;
    logic [5:0]         i_rtc_minute;
    logic [5:0]         i_rtc_second;
    logic [31:0]        i_system_epoch;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_action;
    logic [31:0]        o_target_epoch;
    logic signed [32:0] o_drift_seconds;

    rtc_drift_reconciler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_now_ms        (i_now_ms),
        .i_rtc_year      (i_rtc_year),
        .i_rtc_month     (i_rtc_month),
        .i_rtc_day       (i_rtc_day),
        .i_rtc_hour      (i_rtc_hour),
        .i_rtc_minute    (i_rtc_minute),
        .i_rtc_second    (i_rtc_second),
        .i_system_epoch  (i_system_epoch),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_action        (o_action),
        .o_target_epoch  (o_target_epoch),
        .o_drift_seconds (o_drift_seconds)
    );

    // predictor state and register mirror
    rdr_pkg::t_cfg cfg = '{1'b0, 1'b0, rdr_pkg::CHECK_IVL_RST, rdr_pkg::TRUST_WIN_RST};
    logic [31:0] last_check_ms = '0;
    logic [31:0] last_sync_ms = '0;

    t_beat  pending_q[$];
    t_recon recon_q[$];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_settings = 0;
    int cycles = 0;
    int hold_reqs = 0;
    int act_seen[8] = '{default: 0};
    bit quiet = 1'b0;
    bit burst = 1'b0;

    // stimulus clock and marks
    logic [31:0] clk_ms = '0;
    logic [31:0] chk_mark_ms = '0;
    logic [31:0] sync_mark_ms = '0;

    rdr_pkg::t_cfg dir_cfg [5] = '{
        '{1'b0, 1'b0, rdr_pkg::CHECK_IVL_RST, rdr_pkg::TRUST_WIN_RST},
        '{1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF},
        '{1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0},
        '{1'b1, 1'b0, 32'd0, rdr_pkg::TRUST_WIN_RST},
        '{1'b0, 1'b1, 32'd0, 32'd0}
    };

    t_row dir_tab [21] = '{
        '{0, '{'{rdr_pkg::OP_CHECK, 32'hFFFF_FFFF, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59,
                6'd59, 32'hFFFF_FFFF}, 1'b1, NO_RESULT}},
        '{0, '{'{rdr_pkg::OP_NTP, 32'd0, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0},
                1'b1, NO_RESULT}},
        '{0, '{'{rdr_pkg::OP_TIMER, 32'd0, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0},
                1'b1, NO_RESULT}},
        '{0, '{'{OP_NOP, 32'hFFFF_FFFF, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63,
                32'hFFFF_FFFF}, 1'b1, NO_RESULT}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd100, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd0}, 1'b1, '{rdr_pkg::ACT_IN_TOL, 32'd0, 33'sd0}}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd200, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd1,
                32'd0}, 1'b1, '{rdr_pkg::ACT_IN_TOL, 32'd0, -33'sd1}}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd300, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd2,
                32'd0}, 1'b1, '{rdr_pkg::ACT_SYS_RTC, 32'd2, -33'sd2}}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd400, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd2}, 1'b1, '{rdr_pkg::ACT_SYS_STALE, 32'd0, 33'sd2}}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd500, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0,
                32'hFFFF_FFFF}, 1'b1,
                '{rdr_pkg::ACT_SYS_STALE, 32'd0, 33'sd4294967295}}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd600, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63,
                32'd0}, 1'b1,
                '{rdr_pkg::ACT_SYS_RTC, 32'hFFFF_FFFF, -33'sd4294967295}}},
        '{1, '{'{rdr_pkg::OP_NTP, 32'd1000, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0},
                1'b1, NO_RESULT}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd2000, 12'd2024, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0,
                32'd1709208100}, 1'b0, NO_RESULT}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd3000, 12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd951868795}, 1'b0, NO_RESULT}},
        '{1, '{'{rdr_pkg::OP_CHECK, 32'd4000, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59,
                32'hFFFF_FFFF}, 1'b0, NO_RESULT}},
        '{1, '{'{rdr_pkg::OP_NTP, 32'hFFFF_FFFF, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd0}, 1'b1, NO_RESULT}},
        '{2, '{'{rdr_pkg::OP_TIMER, 32'd5, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0},
                1'b1, NO_RESULT}},
        '{2, '{'{rdr_pkg::OP_CHECK, 32'd3, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd946684810}, 1'b1, NO_RESULT}},
        '{2, '{'{rdr_pkg::OP_CHECK, 32'd4, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd946684810}, 1'b0, NO_RESULT}},
        '{2, '{'{rdr_pkg::OP_CHECK, 32'd4, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd946684810}, 1'b1, NO_RESULT}},
        '{3, '{'{rdr_pkg::OP_CHECK, 32'd0, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd946684810}, 1'b1, NO_RESULT}},
        '{4, '{'{rdr_pkg::OP_CHECK, 32'd0, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                32'd946684810}, 1'b1, NO_RESULT}}
    };

    // March-based days-from-civil, signed 64-bit, truncating division
    function automatic longint civil_seconds(input t_rtc_item it);
        longint y, m, d, hh, mm, ss, days;
        y  = longint'(it.year);
        m  = longint'(it.month);
        d  = longint'(it.day);
        hh = longint'(it.hour);
        mm = longint'(it.minute);
        ss = longint'(it.second);
        if (m <= 2) begin
            y = y - 1;
            m = m + 12;
        end
        days = 365 * y + y / 4 - y / 100 + y / 400 + (153 * (m - 3) + 2) / 5 + d - 719469;
        return days * 86400 + hh * 3600 + mm * 60 + ss;
    endfunction

    function automatic t_recon reconcile(input t_rtc_item it);
        t_recon      r;
        logic [31:0] since_check, since_sync;
        longint      rtc_s, drift, sat, tgt;
        bit          fresh;
        r = NO_RESULT;
        since_check = it.now_ms - last_check_ms;
        since_sync  = it.now_ms - last_sync_ms;
        case (it.opcode)
            rdr_pkg::OP_NTP: last_sync_ms = it.now_ms;
            rdr_pkg::OP_TIMER: last_check_ms = it.now_ms;
            rdr_pkg::OP_CHECK: begin
                if (cfg.rtc_available && cfg.rtc_time_valid &&
                    since_check >= cfg.check_interval_ms) begin
                    last_check_ms = it.now_ms;
                    rtc_s = civil_seconds(it);
                    drift = longint'(it.sys_epoch) - rtc_s;
                    fresh = (last_sync_ms != 0) && (since_sync < cfg.trust_window_ms);
                    sat = drift;
                    if (sat > DRIFT_LIM) sat = DRIFT_LIM;
                    if (sat < -DRIFT_LIM) sat = -DRIFT_LIM;
                    r.drift = sat[32:0];
                    if (drift >= -1 && drift <= 1) begin
                        r.action = rdr_pkg::ACT_IN_TOL;
                    end else if (drift < -1 || !fresh) begin
                        tgt = rtc_s;
                        if (tgt < 0) tgt = 0;
                        if (tgt > EPOCH_TOP) tgt = EPOCH_TOP;
                        r.action = (drift < -1) ? rdr_pkg::ACT_SYS_RTC
                                                : rdr_pkg::ACT_SYS_STALE;
                        r.target = tgt[31:0];
                    end else begin
                        r.action = rdr_pkg::ACT_WRITE_RTC;
                        r.target = it.sys_epoch;
                    end
                end
            end
            default: ;  // unused opcode: no state change
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_ms(input logic [31:0] dflt);
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return dflt;
            3: return 32'($urandom_range(1, 4000));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_rtc_item gen_item();
        t_rtc_item   it;
        int unsigned roll;
        longint      secs;
        roll = $urandom_range(0, 99);
        it.opcode = (roll < 66) ? rdr_pkg::OP_CHECK : (roll < 82) ? rdr_pkg::OP_NTP :
                    (roll < 96) ? rdr_pkg::OP_TIMER : OP_NOP;
        case ($urandom_range(0, 5))
            0, 1: clk_ms = clk_ms + 32'($urandom_range(0, 2000));
            2: clk_ms = chk_mark_ms + cfg.check_interval_ms + 32'($urandom_range(0, 4)) - 32'd2;
            3: clk_ms = sync_mark_ms + cfg.trust_window_ms + 32'($urandom_range(0, 4)) - 32'd2;
            4: clk_ms = clk_ms + cfg.check_interval_ms;
            default: clk_ms = $urandom;
        endcase
        it.now_ms = ($urandom_range(0, 49) == 0) ? 32'd0 : clk_ms;
        if (it.opcode == rdr_pkg::OP_NTP) sync_mark_ms = it.now_ms;
        else if (it.opcode != OP_NOP) chk_mark_ms = it.now_ms;
        if ($urandom_range(0, 9) != 0) begin
            it.year   = 12'($urandom_range(2000, 2099));
            it.month  = 4'($urandom_range(1, 12));
            it.day    = 5'($urandom_range(1, 31));
            it.hour   = 5'($urandom_range(0, 23));
            it.minute = 6'($urandom_range(0, 59));
            it.second = 6'($urandom_range(0, 59));
        end else begin
            {it.year, it.month, it.day, it.hour, it.minute, it.second} =
                38'({$urandom, $urandom});
        end
        secs = civil_seconds(it);
        case ($urandom_range(0, 3))
            0, 1: it.sys_epoch = 32'(secs + longint'($urandom_range(0, 6)) - 3);
            2: it.sys_epoch = 32'(secs + longint'($urandom_range(0, 200000)) - 100000);
            default: it.sys_epoch = $urandom;
        endcase
        return it;
    endfunction

    task automatic report_bad(input string fld, input longint want, input longint got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
    endtask

    task automatic send_item(input t_rtc_item it, input bit fixed, input t_recon res);
        int gap;
        gap = (quiet || burst) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_q.push_back('{it, fixed, res});
        i_in_valid     <= 1'b1;
        i_opcode       <= it.opcode;
        i_now_ms       <= it.now_ms;
        i_rtc_year     <= it.year;
        i_rtc_month    <= it.month;
        i_rtc_day      <= it.day;
        i_rtc_hour     <= it.hour;
        i_rtc_minute   <= it.minute;
        i_rtc_second   <= it.second;
        i_system_epoch <= it.sys_epoch;
        do @(posedge i_clk); while (o_in_stall);
        if (it.opcode != OP_NOP) n_items++;
    endtask

    // called in the step of the last accepted beat
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (recon_q.size() != 0 || pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(input rdr_pkg::t_cfg c);
        wait_drained();
        reg_write(rdr_pkg::REG_RTC_AVAIL, {31'd0, c.rtc_available});
        reg_write(rdr_pkg::REG_RTC_VALID, {31'd0, c.rtc_time_valid});
        reg_write(rdr_pkg::REG_CHECK_IVL, c.check_interval_ms);
        reg_write(rdr_pkg::REG_TRUST_WIN, c.trust_window_ms);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg = c;
        n_settings++;
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     recon_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random stall before each beat, one long hold on request
    initial begin : result_sink
        int stall_left;
        int holds_seen;
        stall_left = 0;
        holds_seen = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_seen) begin
                holds_seen = hold_reqs;
                stall_left = HOLD_CYCLES;
            end else if (o_out_valid && !i_out_stall) begin
                stall_left = quiet ? 0 : $urandom_range(0, 7);
            end
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin : beat_monitor
        t_recon want;
        t_beat  sent;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                act_seen[o_action]++;
                if (recon_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: result beat with nothing expected", $time);
                end else begin
                    want = recon_q.pop_front();
                    if (o_action !== want.action)
                        report_bad("action", want.action, o_action);
                    if (o_target_epoch !== want.target)
                        report_bad("target_epoch", want.target, o_target_epoch);
                    if (o_drift_seconds !== want.drift)
                        report_bad("drift_seconds", want.drift, o_drift_seconds);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                sent = pending_q.pop_front();
                want = reconcile(sent.it);
                recon_q.push_back(sent.fixed ? sent.res : want);
            end
        end
    end

    initial begin : stimulus
        rdr_pkg::t_cfg c;
        int            prev_step;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_in_valid     <= 1'b0;
        i_opcode       <= rdr_pkg::OP_CHECK;
        i_now_ms       <= '0;
        i_rtc_year     <= '0;
        i_rtc_month    <= '0;
        i_rtc_day      <= '0;
        i_rtc_hour     <= '0;
        i_rtc_minute   <= '0;
        i_rtc_second   <= '0;
        i_system_epoch <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_step = 0;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].step != prev_step) begin
                prev_step = dir_tab[k].step;
                apply_cfg(dir_cfg[prev_step]);
            end
            send_item(dir_tab[k].b.it, dir_tab[k].b.fixed, dir_tab[k].b.res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            c.rtc_available     = ($urandom_range(0, 9) != 0);
            c.rtc_time_valid    = ($urandom_range(0, 9) != 0);
            c.check_interval_ms = pick_ms(rdr_pkg::CHECK_IVL_RST);
            c.trust_window_ms   = pick_ms(rdr_pkg::TRUST_WIN_RST);
            apply_cfg(c);
            quiet = (ph % 4 == 3);
            burst = (ph == 1);
            if (burst) hold_reqs++;  // receiver holds off while beats keep coming
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(gen_item(), 1'b0, NO_RESULT);
                if (n % 40 == 39) wait_drained();
            end
            burst = 1'b0;
        end

        wait_drained();
        $display("Covered %0d items and %0d result beats across %0d register settings.",
                 n_items, n_results, n_settings);
        $display("Actions seen: skip %0d, in tolerance %0d, from RTC %0d, stale sync %0d, %s%0d",
                 act_seen[rdr_pkg::ACT_SKIP], act_seen[rdr_pkg::ACT_IN_TOL],
                 act_seen[rdr_pkg::ACT_SYS_RTC], act_seen[rdr_pkg::ACT_SYS_STALE],
                 "RTC write ", act_seen[rdr_pkg::ACT_WRITE_RTC]);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
